// ===== hw/rtl/fdrc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package fdrc_pkg;

  localparam int unsigned MAX_PAYLOAD = 1024;

  localparam int unsigned CNT_W = 17;
  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};
  localparam logic [CNT_W-1:0] HDR_BYTES = CNT_W'(32);

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_A = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_B = 1'b1;

  // request op codes
  localparam logic OP_BYTE  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  // result status codes
  localparam logic [2:0] ST_ACCEPTED = 3'd0;
  localparam logic [2:0] ST_STALE    = 3'd1;
  localparam logic [2:0] ST_SHORT    = 3'd2;
  localparam logic [2:0] ST_MAGIC    = 3'd3;
  localparam logic [2:0] ST_CHANNEL  = 3'd4;
  localparam logic [2:0] ST_RESERVED = 3'd5;
  localparam logic [2:0] ST_LENGTH   = 3'd6;
  localparam logic [2:0] ST_ZERO_ID  = 3'd7;

  // "SRD1", first byte in the top bits
  localparam logic [31:0] MAGIC = 32'h5352_4431;

  // queue between front and back
  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);

  typedef struct packed {
    logic       op;
    logic [7:0] data;
    logic       last;
  } fdrc_req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  channel;
    logic [15:0] body_len;
    logic [63:0] sess_key;
    logic [63:0] sequence_res;
    logic [63:0] timestamp_ms;
  } fdrc_res_t;

  // one queue entry: either a clear command or a finished frame
  // whose status holds every check but the replay check
  typedef struct packed {
    logic        is_clear;
    logic [2:0]  status;
    logic [7:0]  channel;
    logic [15:0] length;
    logic [63:0] session;
    logic [63:0] seq_num;
    logic [63:0] stamp;
  } fdrc_entry_t;

endpackage

`default_nettype wire

// ===== hw/rtl/fdrc_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fdrc_front (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           req_valid,
  input  wire logic                           req_stall,
  input  wire fdrc_pkg::fdrc_req_t            req,
  input  wire logic                           cfg_we,
  input  wire logic [fdrc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]                     cfg_data,
  output logic                                push,
  output fdrc_pkg::fdrc_entry_t               entry
);
  import fdrc_pkg::*;

  logic [7:0]       code_a;
  logic [7:0]       code_b;

  logic [CNT_W-1:0] byte_count;
  logic             magic_ok;
  logic             reserved_ok;
  logic [7:0]       hdr_channel;
  logic [15:0]      hdr_length;
  logic [63:0]      hdr_session;
  logic [63:0]      hdr_sequence;
  logic [63:0]      hdr_time;

  logic [CNT_W-1:0] byte_count_next;
  logic             magic_ok_next;
  logic             reserved_ok_next;
  logic [7:0]       hdr_channel_next;
  logic [15:0]      hdr_length_next;
  logic [63:0]      hdr_session_next;
  logic [63:0]      hdr_sequence_next;
  logic [63:0]      hdr_time_next;

  // values after taking in the current byte
  logic [CNT_W-1:0] cnt_c;
  logic             magic_c;
  logic             res_c;
  logic [7:0]       ch_c;
  logic [15:0]      len_c;
  logic [63:0]      sess_c;
  logic [63:0]      seq_c;
  logic [63:0]      time_c;

  logic             accept;
  logic [CNT_W-1:0] pos;
  logic [7:0]       b;
  logic [2:0]       status;

  assign accept = req_valid && !req_stall;
  assign pos    = byte_count;
  assign b      = req.data;

  always_comb begin
    magic_c = magic_ok;
    res_c   = reserved_ok;
    ch_c    = hdr_channel;
    len_c   = hdr_length;
    sess_c  = hdr_session;
    seq_c   = hdr_sequence;
    time_c  = hdr_time;
    if (pos < CNT_W'(4)) begin
      if (b != MAGIC[{~pos[1:0], 3'b000} +: 8]) magic_c = 1'b0;
    end else if (pos == CNT_W'(4)) begin
      ch_c = b;
    end else if (pos == CNT_W'(5)) begin
      if (b != 8'd0) res_c = 1'b0;
    end else if (pos < CNT_W'(8)) begin
      len_c = {hdr_length[7:0], b};
    end else if (pos < CNT_W'(16)) begin
      sess_c = {hdr_session[55:0], b};
    end else if (pos < CNT_W'(24)) begin
      seq_c = {hdr_sequence[55:0], b};
    end else if (pos < HDR_BYTES) begin
      time_c = {hdr_time[55:0], b};
    end
    cnt_c = (byte_count == COUNT_MAX) ? byte_count : byte_count + CNT_W'(1);
  end

  // every check except replay, in priority order
  always_comb begin
    if (cnt_c < HDR_BYTES) begin
      status = ST_SHORT;
    end else if (!magic_c) begin
      status = ST_MAGIC;
    end else if (ch_c != code_a && ch_c != code_b) begin
      status = ST_CHANNEL;
    end else if (!res_c) begin
      status = ST_RESERVED;
    end else if (len_c == 16'd0 || len_c > 16'(MAX_PAYLOAD) ||
                 cnt_c != HDR_BYTES + CNT_W'(len_c)) begin
      status = ST_LENGTH;
    end else if (sess_c == 64'd0 || seq_c == 64'd0) begin
      status = ST_ZERO_ID;
    end else begin
      status = ST_ACCEPTED;
    end
  end

  always_comb begin
    byte_count_next   = byte_count;
    magic_ok_next     = magic_ok;
    reserved_ok_next  = reserved_ok;
    hdr_channel_next  = hdr_channel;
    hdr_length_next   = hdr_length;
    hdr_session_next  = hdr_session;
    hdr_sequence_next = hdr_sequence;
    hdr_time_next     = hdr_time;
    if (accept && req.op == OP_BYTE) begin
      if (req.last) begin
        byte_count_next   = '0;
        magic_ok_next     = 1'b1;
        reserved_ok_next  = 1'b1;
        hdr_channel_next  = '0;
        hdr_length_next   = '0;
        hdr_session_next  = '0;
        hdr_sequence_next = '0;
        hdr_time_next     = '0;
      end else begin
        byte_count_next   = cnt_c;
        magic_ok_next     = magic_c;
        reserved_ok_next  = res_c;
        hdr_channel_next  = ch_c;
        hdr_length_next   = len_c;
        hdr_session_next  = sess_c;
        hdr_sequence_next = seq_c;
        hdr_time_next     = time_c;
      end
    end
  end

  assign push = accept && (req.op == OP_CLEAR || req.last);

  always_comb begin
    entry.is_clear = (req.op == OP_CLEAR);
    entry.status   = status;
    entry.channel  = ch_c;
    entry.length   = len_c;
    entry.session  = sess_c;
    entry.seq_num  = seq_c;
    entry.stamp    = time_c;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      code_a       <= 8'd0;
      code_b       <= 8'd1;
      byte_count   <= '0;
      magic_ok     <= 1'b1;
      reserved_ok  <= 1'b1;
      hdr_channel  <= '0;
      hdr_length   <= '0;
      hdr_session  <= '0;
      hdr_sequence <= '0;
      hdr_time     <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_CHANNEL_A: code_a <= cfg_data;
          CFG_CHANNEL_B: code_b <= cfg_data;
          default: ;
        endcase
      end
      byte_count   <= byte_count_next;
      magic_ok     <= magic_ok_next;
      reserved_ok  <= reserved_ok_next;
      hdr_channel  <= hdr_channel_next;
      hdr_length   <= hdr_length_next;
      hdr_session  <= hdr_session_next;
      hdr_sequence <= hdr_sequence_next;
      hdr_time     <= hdr_time_next;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/fdrc_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fdrc_queue (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push,
  input  wire fdrc_pkg::fdrc_entry_t wr_entry,
  input  wire logic                  pop,
  output fdrc_pkg::fdrc_entry_t      head,
  output logic                       full,
  output logic                       empty
);
  import fdrc_pkg::*;

  fdrc_entry_t        slots [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_PTR_W:0]   count;
  logic               do_push;
  logic               do_pop;

  assign full    = (count == (Q_PTR_W+1)'(Q_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= wr_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + Q_PTR_W'(1);
      if (do_pop)  rd_ptr <= rd_ptr + Q_PTR_W'(1);
      if (do_push && !do_pop) begin
        count <= count + (Q_PTR_W+1)'(1);
      end else if (do_pop && !do_push) begin
        count <= count - (Q_PTR_W+1)'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/fdrc_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module fdrc_back (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire fdrc_pkg::fdrc_entry_t head,
  input  wire logic                  head_valid,
  output logic                       pop,
  output logic                       res_valid,
  input  wire logic                  res_stall,
  output fdrc_pkg::fdrc_res_t        res
);
  import fdrc_pkg::*;

  logic        order_valid;
  logic [63:0] order_session;
  logic [63:0] order_sequence;
  logic [63:0] order_time;

  logic [63:0] seq_diff;
  logic        seq_after;
  logic        time_ok;
  logic        stale;
  logic [2:0]  final_status;

  // serial-number compare: difference nonzero and below 2^63
  assign seq_diff  = head.seq_num - order_sequence;
  assign seq_after = (seq_diff != 64'd0) && !seq_diff[63];
  assign time_ok   = (head.stamp >= order_time);
  assign stale     = order_valid && (order_session == head.session) &&
                     !(seq_after && time_ok);

  assign final_status = (head.status == ST_ACCEPTED && stale) ? ST_STALE : head.status;

  assign pop = head_valid && (!res_valid || !res_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid      <= 1'b0;
      order_valid    <= 1'b0;
      order_session  <= '0;
      order_sequence <= '0;
      order_time     <= '0;
    end else if (pop) begin
      if (head.is_clear) begin
        res_valid      <= 1'b0;
        order_valid    <= 1'b0;
        order_session  <= '0;
        order_sequence <= '0;
        order_time     <= '0;
      end else begin
        res_valid <= 1'b1;
        if (final_status == ST_ACCEPTED) begin
          order_valid    <= 1'b1;
          order_session  <= head.session;
          order_sequence <= head.seq_num;
          order_time     <= head.stamp;
        end
      end
    end else if (res_valid && !res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && !head.is_clear) begin
      res.status       <= final_status;
      res.channel      <= head.channel;
      res.body_len     <= head.length;
      res.sess_key     <= head.session;
      res.sequence_res <= head.seq_num;
      res.timestamp_ms <= head.stamp;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/frame_deframer_with_replay_check.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel | handshake              | payload
// req     | req_valid / req_stall  | fdrc_req_t: op, data, last
// res     | res_valid / res_stall  | fdrc_res_t: status, header fields
// cfg     | cfg_we                 | cfg_index, cfg_data
//
// One request per cycle while req_stall is low; the front counts and captures each
// accepted byte. A last byte or clear request goes into a 4-entry queue; the back
// applies the replay check to the queue head and registers the result.
// req_stall rises only while the queue is full (back held by res_stall).
// rst is synchronous; frame state, ordering record and codes go to reset values.

module frame_deframer_with_replay_check (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           req_valid,
  output logic                                req_stall,
  input  wire fdrc_pkg::fdrc_req_t            req,
  output logic                                res_valid,
  input  wire logic                           res_stall,
  output fdrc_pkg::fdrc_res_t                 res,
  input  wire logic                           cfg_we,
  input  wire logic [fdrc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]                     cfg_data
);
  import fdrc_pkg::*;

  fdrc_entry_t wr_entry;
  fdrc_entry_t head;
  logic        q_push;
  logic        q_pop;
  logic        q_full;
  logic        q_empty;

  assign req_stall = q_full;

  fdrc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (q_push),
    .entry     (wr_entry)
  );

  fdrc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .wr_entry (wr_entry),
    .pop      (q_pop),
    .head     (head),
    .full     (q_full),
    .empty    (q_empty)
  );

  fdrc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (!q_empty),
    .pop        (q_pop),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res        (res)
  );

`ifndef SYNTHESIS
  a_push_on_accept: assert property (@(posedge clk) disable iff (rst)
    q_push |-> (req_valid && !req_stall))
    else $error("queue push without accepted request");

  a_full_not_empty: assert property (@(posedge clk) disable iff (rst)
    !(q_full && q_empty))
    else $error("queue full and empty together");

  a_result_from_pop: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(q_pop))
    else $error("result appeared without a queue pop");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid after reset");
`endif

endmodule

`default_nettype wire

// ===== dv/tb_frame_deframer_with_replay_check.sv =====
`timescale 1ns / 1ps

module tb_frame_deframer_with_replay_check;
  import fdrc_pkg::*;

  localparam logic [31:0] SYNC_WORD = 32'h5352_4431;  // "SRD1"
  localparam logic [63:0] HALF_RANGE = 64'h8000_0000_0000_0000;

  logic                 clk;
  logic                 rst;
  logic                 req_valid;
  logic                 req_stall;
  fdrc_req_t            req;
  logic                 res_valid;
  logic                 res_stall;
  fdrc_res_t            res;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [7:0]           cfg_data;

  int idle_pct = 0;
  int stall_pct = 0;
  int mismatches = 0;
  int reqs_sent = 0;

  // frame in progress, as the block should see it
  logic [CNT_W-1:0] n_bytes;
  logic             sync_ok;
  logic             pad_ok;
  logic [7:0]       cur_chan;
  logic [15:0]      cur_len;
  logic [63:0]      cur_sess;
  logic [63:0]      cur_seq;
  logic [63:0]      cur_time;
  // ordering record and channel codes
  logic             held;
  logic [63:0]      held_sess;
  logic [63:0]      held_seq;
  logic [63:0]      held_time;
  logic [7:0]       code_a;
  logic [7:0]       code_b;

  fdrc_res_t  due_results[$];
  logic [7:0] doc_q[$];

  frame_deframer_with_replay_check uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    res_stall = 1'b0;
    forever begin
      @(posedge clk);
      res_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  initial begin
    #20_000_000;
    $display("[frame_deframer_with_replay_check] ERROR");
    $finish;
  end

  task automatic clear_frame_state();
    n_bytes = '0;
    sync_ok = 1'b1;
    pad_ok = 1'b1;
    cur_chan = '0;
    cur_len = '0;
    cur_sess = '0;
    cur_seq = '0;
    cur_time = '0;
  endtask

  task automatic clear_record();
    held = 1'b0;
    held_sess = '0;
    held_seq = '0;
    held_time = '0;
  endtask

  // advances the deframer state by one accepted request; on a last byte, queues the frame verdict
  task automatic deframe_req(input fdrc_req_t r);
    fdrc_res_t   v;
    logic [63:0] seq_gap;
    int unsigned pos;
    if (r.op == OP_CLEAR) begin
      clear_record();
      return;
    end
    pos = n_bytes;
    if (pos < 4) begin
      if (r.data != SYNC_WORD[31-8*pos -: 8]) sync_ok = 1'b0;
    end else if (pos == 4) begin
      cur_chan = r.data;
    end else if (pos == 5) begin
      if (r.data != 8'h00) pad_ok = 1'b0;
    end else if (pos < 8) begin
      cur_len = {cur_len[7:0], r.data};
    end else if (pos < 16) begin
      cur_sess = {cur_sess[55:0], r.data};
    end else if (pos < 24) begin
      cur_seq = {cur_seq[55:0], r.data};
    end else if (pos < 32) begin
      cur_time = {cur_time[55:0], r.data};
    end
    if (n_bytes != COUNT_MAX) n_bytes = n_bytes + 1'b1;
    if (!r.last) return;

    seq_gap = cur_seq - held_seq;
    if (n_bytes < HDR_BYTES) v.status = ST_SHORT;
    else if (!sync_ok) v.status = ST_MAGIC;
    else if (cur_chan != code_a && cur_chan != code_b) v.status = ST_CHANNEL;
    else if (!pad_ok) v.status = ST_RESERVED;
    else if (cur_len == 0 || cur_len > MAX_PAYLOAD ||
             n_bytes != HDR_BYTES + CNT_W'(cur_len)) v.status = ST_LENGTH;
    else if (cur_sess == 0 || cur_seq == 0) v.status = ST_ZERO_ID;
    else if (held && held_sess == cur_sess &&
             !(seq_gap != 0 && !seq_gap[63] && cur_time >= held_time)) v.status = ST_STALE;
    else v.status = ST_ACCEPTED;

    if (v.status == ST_ACCEPTED) begin
      held = 1'b1;
      held_sess = cur_sess;
      held_seq = cur_seq;
      held_time = cur_time;
    end
    v.channel = cur_chan;
    v.body_len = cur_len;
    v.sess_key = cur_sess;
    v.sequence_res = cur_seq;
    v.timestamp_ms = cur_time;
    due_results.push_back(v);
    clear_frame_state();
  endtask

  // valid stays high on return; the next push or settle decides what follows
  task automatic push_req(input logic op, input logic [7:0] d, input logic l);
    fdrc_req_t r;
    r.op = op;
    r.data = d;
    r.last = l;
    if ($urandom_range(99) < idle_pct) begin
      req_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    req_valid <= 1'b1;
    req <= r;
    do @(posedge clk); while (req_stall);
    reqs_sent++;
    deframe_req(r);
  endtask

  task automatic settle();
    req_valid <= 1'b0;
    @(posedge clk);
    while (due_results.size() != 0) @(posedge clk);
    // a trailing clear may still sit in the queue
    repeat (8) @(posedge clk);
  endtask

  task automatic set_codes(input logic [7:0] a, input logic [7:0] b);
    cfg_we <= 1'b1;
    cfg_index <= CFG_CHANNEL_A;
    cfg_data <= a;
    @(posedge clk);
    cfg_index <= CFG_CHANNEL_B;
    cfg_data <= b;
    @(posedge clk);
    cfg_we <= 1'b0;
    code_a = a;
    code_b = b;
  endtask

  task automatic build_header(input logic [31:0] sync, input logic [7:0] chan,
                              input logic [7:0] rsv, input logic [15:0] len,
                              input logic [63:0] sess, input logic [63:0] seq,
                              input logic [63:0] tm);
    logic [255:0] hdr;
    hdr = {sync, chan, rsv, len, sess, seq, tm};
    doc_q.delete();
    for (int i = 0; i < 32; i++) doc_q.push_back(hdr[255-8*i -: 8]);
  endtask

  task automatic add_payload(input int n);
    for (int i = 0; i < n; i++) doc_q.push_back(8'($urandom));
  endtask

  // clr_at >= 0 slips a record clear in front of that byte
  task automatic ship_doc(input int clr_at);
    for (int i = 0; i < doc_q.size(); i++) begin
      if (i == clr_at) push_req(OP_CLEAR, 8'($urandom), 1'($urandom));
      push_req(OP_BYTE, doc_q[i], i == doc_q.size() - 1);
    end
  endtask

  task automatic send_frame(input logic [7:0] chan, input logic [15:0] len,
                            input logic [63:0] sess, input logic [63:0] seq,
                            input logic [63:0] tm);
    build_header(SYNC_WORD, chan, 8'h00, len, sess, seq, tm);
    add_payload(len);
    ship_doc(-1);
  endtask

  task automatic test_directed_frames();
    idle_pct = 0;
    stall_pct = 0;
    send_frame(8'h00, 16'd1, 64'd1, 64'd1, 64'd0);
    send_frame(8'h01, 16'd2, 64'd1, 64'd1, 64'd0);       // same sequence
    send_frame(8'h01, 16'd1, 64'd1, 64'd2, 64'd0);       // equal time passes
    send_frame(8'h01, 16'd1, 64'd1, 64'd3, 64'd100);
    send_frame(8'h01, 16'd1, 64'd1, 64'd4, 64'd99);      // time went back
    send_frame(8'h01, 16'd1, 64'd1, 64'd2 + HALF_RANGE, 64'd100);
    send_frame(8'h01, 16'd1, 64'd1, 64'd2 + HALF_RANGE + HALF_RANGE, 64'd100);  // gap = 2^63
    send_frame(8'h01, 16'd1, 64'd1, '1, 64'd100);
    send_frame(8'h01, 16'd1, 64'd1, 64'd1, 64'd100);     // sequence wraps
    send_frame(8'h00, 16'd1, '1, 64'd1, 64'd0);          // new session, older time
    push_req(OP_CLEAR, 8'hFF, 1'b1);
    send_frame(8'h00, 16'd1, '1, 64'd1, 64'd0);          // record gone, accepted again

    doc_q = {8'hFF};
    ship_doc(-1);
    build_header(SYNC_WORD, 8'h01, 8'h00, 16'd1, '1, '1, '1);
    void'(doc_q.pop_back());
    ship_doc(-1);
    build_header(32'h0, 8'hFF, 8'hFF, '1, '1, '1, '1);   // short beats magic
    void'(doc_q.pop_back());
    ship_doc(-1);
    for (int i = 0; i < 4; i++) begin
      build_header(SYNC_WORD ^ (32'h80 << (8 * i)), 8'h07, 8'h01, 16'd1, 64'd9, 64'd9, 64'd9);
      add_payload(1);
      ship_doc(-1);
    end
    build_header(SYNC_WORD, 8'h02, 8'h80, 16'd1, 64'd9, 64'd9, 64'd9);
    add_payload(1);
    ship_doc(-1);
    build_header(SYNC_WORD, 8'h01, 8'h80, 16'd1, 64'd9, 64'd9, 64'd9);
    add_payload(1);
    ship_doc(-1);
    send_frame(8'h01, 16'd0, 64'd9, 64'd9, 64'd9);
    build_header(SYNC_WORD, 8'h01, 8'h00, 16'd1025, 64'd9, 64'd9, 64'd9);
    add_payload(2);
    ship_doc(-1);
    build_header(SYNC_WORD, 8'h01, 8'h00, 16'hFFFF, 64'd9, 64'd9, 64'd9);
    add_payload(2);
    ship_doc(-1);
    build_header(SYNC_WORD, 8'h01, 8'h00, 16'd4, 64'd9, 64'd9, 64'd9);
    add_payload(5);
    ship_doc(-1);
    build_header(SYNC_WORD, 8'h01, 8'h00, 16'd4, 64'd9, 64'd9, 64'd9);
    add_payload(3);
    ship_doc(-1);
    send_frame(8'h01, 16'd1, 64'd0, 64'd9, 64'd9);
    send_frame(8'h01, 16'd1, 64'd9, 64'd0, 64'd9);
    send_frame(8'h01, 16'd8, 64'hFFFF_FFFF_FFFF_FFFE, '1, '1);
    // clear arriving mid-frame leaves the frame alone
    build_header(SYNC_WORD, 8'h00, 8'h00, 16'd3, 64'd5, 64'd1, 64'd1);
    add_payload(3);
    ship_doc(12);
    settle();
  endtask

  task automatic test_channel_codes();
    set_codes(8'hFF, 8'h00);
    send_frame(8'hFF, 16'd1, 64'd77, 64'd1, 64'd0);
    send_frame(8'h00, 16'd1, 64'd78, 64'd1, 64'd0);
    send_frame(8'h01, 16'd1, 64'd79, 64'd1, 64'd0);
    settle();
    set_codes(8'h5A, 8'h5A);
    send_frame(8'h5A, 16'd2, 64'd80, 64'd1, 64'd0);
    send_frame(8'hA5, 16'd2, 64'd81, 64'd1, 64'd0);
    settle();
    set_codes(8'h00, 8'hFF);
    send_frame(8'hFF, 16'd1, 64'd82, 64'd1, 64'd0);
    settle();
  endtask

  task automatic random_doc();
    int          p;
    int          clr_at;
    logic [63:0] sess;
    logic [63:0] seq;
    logic [63:0] tm;
    logic [7:0]  chan;
    logic [15:0] len;
    p = $urandom_range(99);
    if (p < 12) begin
      // stray burst, mostly shorter than a header
      doc_q.delete();
      repeat ($urandom_range(1, 40)) doc_q.push_back(8'($urandom));
      ship_doc(-1);
      return;
    end

    p = $urandom_range(19);
    if (p == 0) sess = '0;
    else if (p < 4) sess = {$urandom, $urandom};
    else if (held && p < 16) sess = held_sess;
    else sess = 64'($urandom_range(1, 3));

    p = $urandom_range(9);
    case (p)
      0: seq = held_seq;
      1: seq = held_seq - 64'($urandom_range(1, 3));
      2: seq = '0;
      3: seq = {$urandom, $urandom};
      4: seq = held_seq + HALF_RANGE - 64'($urandom_range(0, 1));
      default: seq = held_seq + 64'($urandom_range(1, 4));
    endcase

    p = $urandom_range(11);
    if (p == 0) tm = held_time - 64'd1;
    else if (p == 1) tm = {$urandom, $urandom};
    else tm = held_time + 64'($urandom_range(0, 50));

    p = $urandom_range(19);
    if (p < 9) chan = code_a;
    else if (p < 18) chan = code_b;
    else chan = 8'($urandom);

    p = $urandom_range(99);
    if (p == 0) len = 16'($urandom_range(100, 1024));
    else if (p == 1) len = 16'($urandom_range(1025, 65535));
    else len = 16'($urandom_range(1, 8));

    build_header(SYNC_WORD, chan, 8'h00, len, sess, seq, tm);
    add_payload(len > MAX_PAYLOAD ? 2 : int'(len));

    p = $urandom_range(99);
    if (p < 4) doc_q[$urandom_range(0, 31)] ^= 8'(1 << $urandom_range(0, 7));
    else if (p < 8) repeat ($urandom_range(1, 3)) void'(doc_q.pop_back());
    else if (p < 11) add_payload($urandom_range(1, 3));
    else if (p < 13) doc_q[5] = 8'($urandom_range(1, 255));

    clr_at = ($urandom_range(19) == 0) ? $urandom_range(0, doc_q.size() - 1) : -1;
    ship_doc(clr_at);
  endtask

  task automatic test_random_traffic(input logic [7:0] a, input logic [7:0] b,
                                     input int snd_idle, input int rcv_stall, input int n);
    int target;
    set_codes(a, b);
    idle_pct = snd_idle;
    stall_pct = rcv_stall;
    target = reqs_sent + n;
    while (reqs_sent < target) begin
      if ($urandom_range(19) == 0) push_req(OP_CLEAR, 8'($urandom), 1'($urandom));
      random_doc();
      if ($urandom_range(24) == 0) settle();
    end
    settle();
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    fdrc_res_t want;
    if (!rst && res_valid && !res_stall) begin
      if (due_results.size() == 0) begin
        $display("%0t: result with nothing pending: expected none, got %h", $time, res);
        mismatches++;
      end else begin
        want = due_results.pop_front();
        check_field("status", 64'(want.status), 64'(res.status));
        check_field("channel", 64'(want.channel), 64'(res.channel));
        check_field("body_len", 64'(want.body_len), 64'(res.body_len));
        check_field("sess_key", want.sess_key, res.sess_key);
        check_field("sequence_res", want.sequence_res, res.sequence_res);
        check_field("timestamp_ms", want.timestamp_ms, res.timestamp_ms);
      end
    end
  end

  initial begin
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    code_a = 8'h00;
    code_b = 8'h01;
    clear_frame_state();
    clear_record();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_frames();
    test_channel_codes();
    test_random_traffic(8'h00, 8'h01, 0, 0, 130);
    test_random_traffic(8'hFF, 8'h00, 64, 0, 130);
    test_random_traffic(8'($urandom), 8'($urandom), 0, 64, 130);
    test_random_traffic(8'h00, 8'hFF, 20, 20, 130);

    if (mismatches == 0 && due_results.size() == 0)
      $display("[frame_deframer_with_replay_check] OK");
    else
      $display("[frame_deframer_with_replay_check] ERROR");
    $finish;
  end

endmodule
